// ===== rtl/core/dtb_pkg.sv =====
package dtb_pkg;

	// tile geometry and grid
	localparam int TILE_W    = 16;
	localparam int TILE_H    = 16;
	localparam int X_TILES   = 32;
	localparam int Y_TILES   = 64;
	localparam int MASK_ROWS = 64;
	localparam int MASK_BITS = 32;

	localparam int WALK_ROWS = (Y_TILES < MASK_ROWS) ? Y_TILES : MASK_ROWS;
	localparam int WALK_COLS = (X_TILES < MASK_BITS) ? X_TILES : MASK_BITS;

	localparam int ROW_W  = $clog2(MASK_ROWS);
	localparam int COL_W  = $clog2(MASK_BITS);
	localparam int LINE_W = (TILE_H > 1) ? $clog2(TILE_H) : 1;
	localparam int PIX_W  = (TILE_W > 1) ? $clog2(TILE_W) : 1;
	localparam int FBL_W  = $clog2(MASK_ROWS * TILE_H);
	localparam int COLX_W = $clog2(MASK_BITS * TILE_W);

	// rows and columns that take part in the walk
	localparam logic [MASK_BITS-1:0] COL_KEEP = {MASK_BITS{1'b1}} >> (MASK_BITS - WALK_COLS);
	localparam logic [MASK_ROWS-1:0] ROW_KEEP = {MASK_ROWS{1'b1}} >> (MASK_ROWS - WALK_ROWS);

	// register reset values
	localparam logic [31:0] FB_BASE_RST = 32'hC000_0000;
	localparam logic [15:0] STRIDE_RST  = 16'd768;

	// request kinds
	localparam logic CMD_MASK  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// one pixel request handed to the address pipeline
	typedef struct packed {
		logic [FBL_W-1:0]  fb_line;
		logic [COLX_W-1:0] colx;
		logic [31:0]       pixel;
		logic              done;
		logic              overrun;
	} blit_item_t;

	// mask ram access: one write and one read port
	typedef struct packed {
		logic                 we;
		logic [ROW_W-1:0]     waddr;
		logic [MASK_BITS-1:0] wdata;
		logic                 re;
		logic [ROW_W-1:0]     raddr;
	} mask_req_t;

	// lowest set column of a row mask
	function automatic logic [COL_W-1:0] lowest_col(input logic [MASK_BITS-1:0] m);
		logic [COL_W-1:0] idx;
		idx = '0;
		for (int i = MASK_BITS - 1; i >= 0; i--) begin
			if (m[i]) idx = COL_W'(i);
		end
		return idx;
	endfunction

	// lowest set row of a row vector
	function automatic logic [ROW_W-1:0] lowest_row(input logic [MASK_ROWS-1:0] m);
		logic [ROW_W-1:0] idx;
		idx = '0;
		for (int i = MASK_ROWS - 1; i >= 0; i--) begin
			if (m[i]) idx = ROW_W'(i);
		end
		return idx;
	endfunction

	// a row has work when it is in the grid and has a walked column marked
	function automatic logic row_live(input logic [ROW_W-1:0] row,
			input logic [MASK_BITS-1:0] mask);
		return ROW_KEEP[row] && (|(mask & COL_KEEP));
	endfunction

endpackage

// ===== rtl/core/dtb_mask_store.sv =====
module dtb_mask_store import dtb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mask_req_t            req,
	output logic [MASK_BITS-1:0] rdata,
	output logic [MASK_ROWS-1:0] live
);

	logic [MASK_BITS-1:0] mem [MASK_ROWS];
	logic [MASK_BITS-1:0] rdata_q;
	logic [MASK_ROWS-1:0] live_q;

	// change mask ram, registered read
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		if (req.re) rdata_q <= mem[req.raddr];
	end

	// per-row work flags, a row only reads the ram once it is flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (req.we) begin
			live_q[req.waddr] <= row_live(req.waddr, req.wdata);
		end
	end

	assign rdata = rdata_q;
	assign live  = live_q;

endmodule

// ===== rtl/core/dtb_walker.sv =====
module dtb_walker import dtb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_cmd,
	input  logic [ROW_W-1:0]     in_row,
	input  logic [31:0]          in_mask,
	input  logic [31:0]          in_pixel,
	input  logic                 item_ready,
	output logic                 item_valid,
	output blit_item_t           item,
	output mask_req_t            mreq,
	input  logic [MASK_BITS-1:0] rdata,
	input  logic [MASK_ROWS-1:0] live
);

	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [LINE_W-1:0]    line_q;
	logic [PIX_W-1:0]     pix_q;
	logic                 fin_q;
	logic                 cur_ok_q;
	logic [MASK_BITS-1:0] rem_q;
	logic                 nxt_vld_q;
	logic [MASK_BITS-1:0] nxt_mask_q;
	logic                 rd_pend_q;
	logic                 rd_cur_q;

	logic [MASK_ROWS-1:0] nxt_bits;
	logic                 nxt_any;
	logic [ROW_W-1:0]     nxt_row;
	logic [MASK_ROWS-1:0] live_nx;
	logic                 pix_last;
	logic                 line_last;
	logic                 row_change;
	logic                 pix_ok;
	logic                 acc;
	logic                 load;
	logic                 pix;
	logic                 issue_cur;
	logic                 issue_nxt;

	// next flagged row below the current one
	assign nxt_bits = live & (({MASK_ROWS{1'b1}} << row_q) << 1);
	assign nxt_any  = |nxt_bits;
	assign nxt_row  = lowest_row(nxt_bits);

	// row flags as they stand after a mask load
	always_comb begin
		live_nx = live;
		live_nx[in_row] = row_live(in_row, in_mask);
	end

	// position in the tile
	assign pix_last   = (pix_q == PIX_W'(TILE_W - 1));
	assign line_last  = (line_q == LINE_W'(TILE_H - 1));
	assign row_change = pix_last && line_last && (rem_q == '0);

	// interlock: current row known, next row prefetched when this pixel leaves the row
	assign pix_ok   = fin_q || (cur_ok_q && (!row_change || !nxt_any || nxt_vld_q));
	assign in_ready = item_ready && pix_ok;
	assign acc      = in_valid && in_ready;
	assign load     = acc && (in_cmd == CMD_MASK);
	assign pix      = acc && (in_cmd == CMD_PIXEL);

	// mask ram reads: current row after a restart, then the next row ahead of time
	assign issue_cur = !fin_q && !cur_ok_q && !rd_pend_q && !load;
	assign issue_nxt = !fin_q && cur_ok_q && nxt_any && !nxt_vld_q && !rd_pend_q && !load;

	always_comb begin
		mreq.we    = load;
		mreq.waddr = in_row;
		mreq.wdata = in_mask & COL_KEEP;
		mreq.re    = issue_cur || issue_nxt;
		mreq.raddr = issue_cur ? row_q : nxt_row;
	end

	// pixel request for the address pipeline
	assign item_valid = pix;
	always_comb begin
		item.fb_line = FBL_W'(FBL_W'(row_q) * FBL_W'(TILE_H) + FBL_W'(line_q));
		item.colx    = COLX_W'(COLX_W'(col_q) * COLX_W'(TILE_W) + COLX_W'(pix_q));
		item.pixel   = in_pixel;
		item.done    = !fin_q && row_change && !nxt_any;
		item.overrun = fin_q;
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			line_q     <= '0;
			pix_q      <= '0;
			fin_q      <= 1'b1;
			cur_ok_q   <= 1'b0;
			rem_q      <= '0;
			nxt_vld_q  <= 1'b0;
			nxt_mask_q <= '0;
			rd_pend_q  <= 1'b0;
			rd_cur_q   <= 1'b0;
		end else begin
			// read data returns, dropped when a mask load restarts the walk
			if (rd_pend_q && !load) begin
				rd_pend_q <= 1'b0;
				if (rd_cur_q) begin
					col_q    <= lowest_col(rdata);
					rem_q    <= rdata & (rdata - MASK_BITS'(1));
					cur_ok_q <= 1'b1;
				end else begin
					nxt_mask_q <= rdata;
					nxt_vld_q  <= 1'b1;
				end
			end
			if (issue_cur || issue_nxt) begin
				rd_pend_q <= 1'b1;
				rd_cur_q  <= issue_cur;
			end
			// step through pixels, lines, tiles and rows
			if (pix && !fin_q) begin
				if (pix_last) begin
					pix_q <= '0;
					if (line_last) begin
						line_q <= '0;
						if (rem_q != '0) begin
							col_q <= lowest_col(rem_q);
							rem_q <= rem_q & (rem_q - MASK_BITS'(1));
						end else if (nxt_any) begin
							row_q     <= nxt_row;
							col_q     <= lowest_col(nxt_mask_q);
							rem_q     <= nxt_mask_q & (nxt_mask_q - MASK_BITS'(1));
							nxt_vld_q <= 1'b0;
						end else begin
							fin_q    <= 1'b1;
							row_q    <= '0;
							col_q    <= '0;
							cur_ok_q <= 1'b0;
						end
					end else begin
						line_q <= line_q + LINE_W'(1);
					end
				end else begin
					pix_q <= pix_q + PIX_W'(1);
				end
			end
			// mask load restarts the walk at the first flagged row
			if (load) begin
				row_q     <= (|live_nx) ? lowest_row(live_nx) : '0;
				col_q     <= '0;
				line_q    <= '0;
				pix_q     <= '0;
				fin_q     <= !(|live_nx);
				cur_ok_q  <= 1'b0;
				nxt_vld_q <= 1'b0;
				rd_pend_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// never two reads in flight
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_q |-> !mreq.re)
		else $error("mask read issued while one is outstanding");

	// a real pixel only walks a row whose mask is loaded
	assert property (@(posedge clk) disable iff (!arst_n) (pix && !fin_q) |-> cur_ok_q)
		else $error("pixel taken before current row mask arrived");

	// crossing into a new row uses a prefetched mask
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix && !fin_q && row_change && nxt_any) |-> nxt_vld_q)
		else $error("row change without prefetched mask");

	// walked row is always a flagged row
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_ok_q && !fin_q) |-> live[row_q])
		else $error("walking a row without work");

	// last pixel of the frame ends the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix && item.done && !load) |=> fin_q)
		else $error("frame end did not finish the walk");
`endif

endmodule

// ===== rtl/core/dtb_addr_pipe.sv =====
module dtb_addr_pipe import dtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] fb_base,
	input  logic [15:0] line_stride,
	input  logic        in_valid,
	output logic        in_ready,
	input  blit_item_t  in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_address,
	output logic [31:0] out_data,
	output logic        out_done,
	output logic        out_overrun
);

	logic        v_s1;
	blit_item_t  item_s1;
	logic        v_s2;
	logic [31:0] off_s2;
	logic [31:0] pixel_s2;
	logic        done_s2;
	logic        ovr_s2;
	logic        out_valid_q;
	logic [31:0] addr_q;
	logic [31:0] data_q;
	logic        done_q;
	logic        ovr_q;

	logic        out_go;
	logic        s2_go;
	logic        s1_go;

	// each stage moves when the one after it has room
	assign out_go   = !out_valid_q || out_ready;
	assign s2_go    = !v_s2 || out_go;
	assign s1_go    = !v_s1 || s2_go;
	assign in_ready = s1_go;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_go) v_s1 <= in_valid;
			if (s2_go) v_s2 <= v_s1;
			if (out_go) out_valid_q <= v_s2;
		end
	end

	// s1 capture, s2 line offset multiply, output base add
	always_ff @(posedge clk) begin
		if (s1_go && in_valid) item_s1 <= in_item;
		if (s2_go && v_s1) begin
			off_s2   <= 32'(item_s1.fb_line) * 32'(line_stride) + 32'(item_s1.colx);
			pixel_s2 <= item_s1.pixel;
			done_s2  <= item_s1.done;
			ovr_s2   <= item_s1.overrun;
		end
		if (out_go && v_s2) begin
			addr_q <= ovr_s2 ? 32'd0 : fb_base + {off_s2[29:0], 2'b00};
			data_q <= ovr_s2 ? 32'd0 : pixel_s2;
			done_q <= done_s2;
			ovr_q  <= ovr_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = addr_q;
	assign out_data    = data_q;
	assign out_done    = done_q;
	assign out_overrun = ovr_q;

endmodule

// ===== rtl/core/delta_tile_blit_address_gen.sv =====
// Delta-frame tile blitter address generator. Mask requests (tuser 0) store the change
// mask of one tile row and restart the walk at the first changed tile; pixel requests
// (tuser 1) then get one framebuffer write each, tiles taken top to bottom and left to
// right, each tile line by line, at fb_base + 4*((row*16+line)*line_stride + col*16 + x).
// The last pixel of the last changed tile carries frame_done; a pixel with no tile left
// comes out with overrun set and zero address and data. One request is taken per cycle
// while the write stream has room and the row masks are at hand; each result passes the
// s1, s2 and output registers. After a mask load that leaves a changed tile, no request
// is taken until the mask ram returns the first changed row; row crossings use a mask
// read ahead from the same ram, so 16x16 tiles never wait for it. The mask ram needs no
// clearing pass after reset. The user must write fb_base (address 0, reset 0xC0000000) and
// line_stride (address 4, reset 768) only while the block is idle; the block does not enforce it.
module delta_tile_blit_address_gen import dtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // row_index[5:0], change_mask[37:6], pixel_word[69:38]
	input  logic        s_tuser,  // cmd
	// write stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // write_address[31:0], write_data[63:32]
	output logic [1:0]  m_tuser   // frame_done[0], overrun[1]
);

	localparam logic REG_FB_BASE = 1'b0;
	localparam logic REG_STRIDE  = 1'b1;

	logic [31:0]          fb_base_q;
	logic [15:0]          stride_q;
	logic                 reg_wr;
	logic                 reg_idx;

	logic                 item_ready;
	logic                 item_valid;
	blit_item_t           item;
	mask_req_t            mreq;
	logic [MASK_BITS-1:0] rdata;
	logic [MASK_ROWS-1:0] live;

	// register writes
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q <= FB_BASE_RST;
			stride_q  <= STRIDE_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_FB_BASE: fb_base_q <= pwdata;
				REG_STRIDE:  stride_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_FB_BASE: prdata = fb_base_q;
			REG_STRIDE:  prdata = {16'd0, stride_q};
			default:     prdata = 32'd0;
		endcase
	end

	dtb_mask_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata),
		.live   (live)
	);

	dtb_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_row     (s_tdata[5:0]),
		.in_mask    (s_tdata[37:6]),
		.in_pixel   (s_tdata[69:38]),
		.item_ready (item_ready),
		.item_valid (item_valid),
		.item       (item),
		.mreq       (mreq),
		.rdata      (rdata),
		.live       (live)
	);

	dtb_addr_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.fb_base     (fb_base_q),
		.line_stride (stride_q),
		.in_valid    (item_valid),
		.in_ready    (item_ready),
		.in_item     (item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_address (m_tdata[31:0]),
		.out_data    (m_tdata[63:32]),
		.out_done    (m_tuser[0]),
		.out_overrun (m_tuser[1])
	);

endmodule

// ===== tb/blit_write_checker.sv =====
`timescale 1ns / 100ps
module blit_write_checker import dtb_pkg::*; #(
	parameter logic [2:0] BASE_REG   = 3'd0,
	parameter logic [2:0] STRIDE_REG = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,  // row_index[5:0], change_mask[37:6], pixel_word[69:38]
	input  logic        s_tuser,  // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,  // write_address[31:0], write_data[63:32]
	input  logic [1:0]  m_tuser,  // frame_done[0], overrun[1]
	output int          mismatches,
	output int          pending,
	output int          writes_seen,
	output int          frames_done,
	output int          overruns
);

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] data;
		logic        done;
		logic        overrun;
	} fb_write_t;

	fb_write_t write_queue[$];

	// own copy of the tile walk and the registers
	logic [MASK_BITS-1:0] tile_masks [MASK_ROWS];
	int unsigned          at_row;
	int unsigned          at_col;
	int unsigned          at_line;
	int unsigned          at_pix;
	bit                   frame_idle;
	logic [31:0]          fb_base;
	logic [15:0]          pitch;

	// first marked tile at or after (row, col) in walk order
	function automatic bit seek_marked(input int unsigned row, input int unsigned col);
		for (int unsigned r = row; r < WALK_ROWS; r++) begin
			for (int unsigned c = (r == row) ? col : 0; c < WALK_COLS; c++) begin
				if (tile_masks[r][c]) begin
					at_row = r;
					at_col = c;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// a mask load restarts at the first changed tile of the frame
	function automatic void restart_walk();
		at_line = 0;
		at_pix = 0;
		at_row = 0;
		at_col = 0;
		frame_idle = !seek_marked(0, 0);
		if (frame_idle) begin
			at_row = 0;
			at_col = 0;
		end
	endfunction

	// framebuffer write for one pixel, then step through the tile
	function automatic fb_write_t blit_pixel(input logic [31:0] pix);
		fb_write_t   w;
		logic [31:0] line_no;
		logic [31:0] offset;
		w = '0;
		if (frame_idle) begin
			w.overrun = 1'b1;
			return w;
		end
		line_no = 32'(at_row * TILE_H + at_line);
		offset = line_no * 32'(pitch) + 32'(at_col * TILE_W + at_pix);
		w.addr = fb_base + (offset << 2);
		w.data = pix;
		at_pix++;
		if (at_pix >= TILE_W) begin
			at_pix = 0;
			at_line++;
			if (at_line >= TILE_H) begin
				at_line = 0;
				if (!seek_marked(at_row, at_col + 1)) begin
					frame_idle = 1'b1;
					at_row = 0;
					at_col = 0;
					w.done = 1'b1;
				end
			end
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fb_write_t want;
		fb_write_t got;
		if (!arst_n) begin
			for (int r = 0; r < MASK_ROWS; r++) tile_masks[r] = '0;
			at_row = 0;
			at_col = 0;
			at_line = 0;
			at_pix = 0;
			frame_idle = 1'b1;
			fb_base = FB_BASE_RST;
			pitch = STRIDE_RST;
			write_queue.delete();
			pending = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == BASE_REG) fb_base = pwdata;
				else if (paddr == STRIDE_REG) pitch = pwdata[15:0];
			end
			// accepted request
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_MASK) begin
					tile_masks[s_tdata[5:0]] = s_tdata[37:6];
					restart_walk();
				end else begin
					write_queue.push_back(blit_pixel(s_tdata[69:38]));
				end
			end
			// accepted write against the oldest expected one
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]};
				writes_seen++;
				if (write_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected write: addr %h data %h done %b overrun %b",
							got.addr, got.data, got.done, got.overrun);
				end else begin
					want = write_queue.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"write mismatch: expected addr %h data %h done %b ",
								"overrun %b, got addr %h data %h done %b overrun %b"},
								want.addr, want.data, want.done, want.overrun,
								got.addr, got.data, got.done, got.overrun);
					end
					if (want.done) frames_done++;
					if (want.overrun) overruns++;
				end
			end
			pending = write_queue.size();
		end
	end

endmodule

// ===== tb/delta_tile_blit_address_gen_test.sv =====
`timescale 1ns / 100ps
module delta_tile_blit_address_gen_test;
	import dtb_pkg::*;

	localparam logic [2:0] REG_FB_BASE     = 3'd0;
	localparam logic [2:0] REG_LINE_STRIDE = 3'd4;
	localparam int STALL_LIMIT    = 3000;
	localparam int REQUEST_TARGET = 1650;
	localparam int TILE_PIXELS    = TILE_W * TILE_H;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // row_index[5:0], change_mask[37:6], pixel_word[69:38]
	logic        s_tuser;  // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;  // write_address[31:0], write_data[63:32]
	logic [1:0]  m_tuser;  // frame_done[0], overrun[1]

	int mismatches;
	int pending;
	int writes_seen;
	int frames_done;
	int overruns;
	int requests;
	int settings;
	int idle_cycles;
	bit quiet;
	bit hold_req;
	logic [MASK_ROWS-1:0] rows_marked;

	delta_tile_blit_address_gen i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	blit_write_checker #(
		.BASE_REG   (REG_FB_BASE),
		.STRIDE_REG (REG_LINE_STRIDE)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.pending     (pending),
		.writes_seen (writes_seen),
		.frames_done (frames_done),
		.overruns    (overruns)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// one request on the input stream, then an optional gap
	task automatic send_req(input logic cmd, input logic [5:0] row, input logic [31:0] mask,
			input logic [31:0] pix);
		int unsigned pick;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, pix, mask, row};
		do @(posedge clk); while (!s_tready);
		requests++;
		pick = $urandom_range(0, 99);
		if (!quiet && pick >= 70) begin
			s_tvalid <= 1'b0;
			repeat ((pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
		end
	endtask

	task automatic load_mask(input logic [5:0] row, input logic [31:0] mask);
		send_req(CMD_MASK, row, mask, $urandom);
	endtask

	task automatic send_pixel(input logic [31:0] pix);
		send_req(CMD_PIXEL, 6'($urandom), $urandom, pix);
	endtask

	// stop offering and wait for every expected write plus the pipeline tail
	task automatic drain_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup and access cycle; the caller drops psel afterwards
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_regs(input logic [31:0] base, input logic [15:0] stride);
		drain_idle();
		reg_write(REG_FB_BASE, base);
		reg_write(REG_LINE_STRIDE, stride);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	// write side: random stalls, calm stretches and one long hold-off on request
	initial begin
		int unsigned pick;
		m_tready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet || pick < 65) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ((pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
			end
		end
	end

	// cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		@(posedge clk);
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned npix;
		int unsigned tiles;
		int          phase;
		logic [5:0]  row_a;
		logic [5:0]  row_b;
		logic [31:0] mask_a;
		logic [31:0] mask_b;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_MASK;
		quiet = 1'b0;
		hold_req = 1'b0;
		requests = 0;
		settings = 0;
		idle_cycles = 0;
		rows_marked = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pixel with nothing loaded, corner tile, empty frame, mid-frame reload
		send_pixel($urandom);
		load_mask(6'd63, 32'h8000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'hA5A5_5A5A);
		load_mask(6'd63, 32'h0000_0000);
		send_pixel($urandom);
		load_mask(6'd0, 32'hFFFF_FFFF);
		send_pixel($urandom);
		send_pixel($urandom);
		send_pixel($urandom);
		load_mask(6'd0, 32'h0000_0002);
		send_pixel($urandom);
		send_pixel($urandom);
		load_mask(6'd0, 32'h0000_0000);
		send_pixel($urandom);
		drain_idle();

		// random frames of one or two changed tiles
		phase = 1;
		while (requests < REQUEST_TARGET) begin
			quiet = ($urandom_range(0, 3) == 0);
			if (phase == 1)
				set_regs(32'h0000_0000, 16'd1);
			else if (phase == 2)
				set_regs(32'hFFFF_FFFF, 16'hFFFF);
			else if ($urandom_range(0, 3) == 0)
				set_regs(($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom,
					($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 40)) :
					16'($urandom_range(1, 65535)));

			// clear the rows of the previous frame
			for (int r = 0; r < MASK_ROWS; r++)
				if (rows_marked[r]) load_mask(6'(r), '0);
			rows_marked = '0;

			// noise: a dense mask loaded and wiped, a stray pixel with no tile left
			if ($urandom_range(0, 2) == 0) begin
				row_b = 6'($urandom);
				load_mask(row_b, $urandom);
				load_mask(row_b, '0);
			end
			if ($urandom_range(0, 3) == 0) send_pixel($urandom);

			row_a = 6'($urandom);
			mask_a = 32'h1 << $urandom_range(0, WALK_COLS - 1);
			tiles = 1;
			if ($urandom_range(0, 2) == 0) begin
				row_b = 6'($urandom);
				mask_b = 32'h1 << $urandom_range(0, WALK_COLS - 1);
				if (row_b == row_a) begin
					mask_a |= mask_b;
					tiles = $countones(mask_a);
				end else begin
					load_mask(row_b, mask_b);
					rows_marked[row_b] = 1'b1;
					tiles = 2;
				end
			end
			load_mask(row_a, mask_a);
			rows_marked[row_a] = 1'b1;

			pick = (phase == 1) ? 99 : $urandom_range(0, 99);
			if (pick < 45) begin
				npix = $urandom_range(1, 80);
			end else begin
				if (pick < 60) begin
					repeat ($urandom_range(1, TILE_PIXELS - 1)) send_pixel($urandom);
					load_mask(row_a, mask_a);
				end
				npix = tiles * TILE_PIXELS + $urandom_range(0, 3);
			end
			if (phase == 1) hold_req = 1'b1;
			repeat (npix) send_pixel($urandom);
			if ($urandom_range(0, 3) == 0) drain_idle();
			phase++;
		end

		drain_idle();
		$display("run: %0d requests, %0d writes checked, %0d frames completed, %0d overruns",
			requests, writes_seen, frames_done, overruns);
		$display("register settings applied: %0d, mismatches: %0d", settings, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
